[sv/char_byte_offset_map_macros.svh]
// ----------------------------------------------------------------------------
// char_byte_offset_map_macros
// Assertion macros shared by the checker of the offset map.
// ----------------------------------------------------------------------------
`ifndef CHAR_BYTE_OFFSET_MAP_MACROS_SVH
`define CHAR_BYTE_OFFSET_MAP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CBOM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define CBOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/cbom_pkg.sv]
// ----------------------------------------------------------------------------
// cbom_pkg
// Types and codes shared by the character/byte offset map.
// ----------------------------------------------------------------------------
package cbom_pkg;

    localparam int OP_W       = 3;
    localparam int CHAR_W     = 16;
    localparam int BYTE_IN_W  = 21;
    localparam int RANGE_W    = 49;
    localparam int BYTE_RES_W = 49;
    localparam int LOCAL_W    = 20;
    localparam int WOFF_W     = 48;
    localparam int COUNT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD         = 3'd0,
        OP_CHAR_LOCAL   = 3'd1,
        OP_CHAR_GLOBAL  = 3'd2,
        OP_BYTE_TO_CHAR = 3'd3,
        OP_CLIP         = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BOUNDS   = 2'd1,
        STAT_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_OFFSET = 2'd0,
        CFG_WINDOW_SIZE   = 2'd1,
        CFG_CHAR_COUNT    = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SEARCH,
        S_CLIP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic lookup;
        logic search;
        logic clip;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic search_done;
    } t_stat;

endpackage

[sv/cbom_ctrl.sv]
// ----------------------------------------------------------------------------
// cbom_ctrl
// Sequencer for the offset map: one word in flight, output register handshake.
// ----------------------------------------------------------------------------
module cbom_ctrl
    import cbom_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    case (i_stat.op)
                        OP_CHAR_LOCAL, OP_CHAR_GLOBAL: n_state = S_LOOKUP;
                        OP_BYTE_TO_CHAR:               n_state = S_SEARCH;
                        OP_CLIP:                       n_state = S_CLIP;
                        default:                       n_state = S_FINISH;
                    endcase
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_FINISH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.search_done) begin
                    n_state = S_FINISH;
                end
            end
            S_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                // move result into the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/cbom_dpath.sv]
// ----------------------------------------------------------------------------
// cbom_dpath
// Offset table memory, window registers, lower-bound search and range clip.
// ----------------------------------------------------------------------------
module cbom_dpath
    import cbom_pkg::*;
#(
    parameter int MAX_CHARS       = 16384,
    parameter int LOCAL_BYTE_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [OP_W-1:0]              i_op,
    input  logic signed [CHAR_W-1:0]     i_char_index,
    input  logic signed [BYTE_IN_W-1:0]  i_byte_offset,
    input  logic signed [RANGE_W-1:0]    i_range_location,
    input  logic signed [RANGE_W-1:0]    i_range_length,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    output logic [1:0]                   o_status,
    output logic [BYTE_RES_W-1:0]        o_byte_result,
    output logic signed [CHAR_W-1:0]     o_char_result,
    output logic [LOCAL_W-1:0]           o_clip_location,
    output logic [LOCAL_W-1:0]           o_clip_length
);

    localparam int CNT_W = $clog2(MAX_CHARS + 2);
    localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int KEY_W = (LOCAL_BYTE_BITS > LOCAL_W) ? LOCAL_BYTE_BITS : LOCAL_W;
    localparam int CLIP_W = RANGE_W + 1;

    // window registers
    logic [WOFF_W-1:0]  r_window_offset;
    logic [LOCAL_W-1:0] r_window_size;
    logic [COUNT_W-1:0] r_char_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_offset <= '0;
            r_window_size   <= '0;
            r_char_count    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_WINDOW_OFFSET: r_window_offset <= i_cfg_data[WOFF_W-1:0];
                CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[LOCAL_W-1:0];
                CFG_CHAR_COUNT:    r_char_count    <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // live count, clamped to table depth; index live_n is the sentinel
    logic [CNT_W-1:0] live_n;
    always_comb begin
        if (32'(r_char_count) > 32'(MAX_CHARS)) begin
            live_n = CNT_W'(MAX_CHARS);
        end else begin
            live_n = CNT_W'(r_char_count);
        end
    end

    t_op in_op;
    assign in_op = t_op'(i_op);

    logic load_ok, lookup_ok;
    assign load_ok   = !i_char_index[CHAR_W-1]
                       && (32'(i_char_index[CHAR_W-2:0]) < 32'(MAX_CHARS));
    assign lookup_ok = !i_char_index[CHAR_W-1]
                       && (32'(i_char_index[CHAR_W-2:0]) <= 32'(live_n));

    // latched word
    t_op                        r_op;
    logic                       r_lk_ok;
    logic signed [BYTE_IN_W-1:0] r_bo;
    logic signed [RANGE_W-1:0]  r_rlen;
    logic signed [CLIP_W-1:0]   r_diff;
    logic                       r_clip_pos;

    // search state
    logic [CNT_W-1:0] r_lo, r_len, r_probe;
    logic [CNT_W-1:0] n_lo, n_len, next_probe, probe0, rd_idx;
    logic [CNT_W-1:0] probe_inc;
    logic [KEY_W-1:0] entry;
    logic             less;

    // table memory, registered read
    logic [LOCAL_BYTE_BITS-1:0] r_mem [MAX_CHARS];
    logic [LOCAL_BYTE_BITS-1:0] r_rd_data;
    logic                       r_rd_sent;

    assign probe0 = CNT_W'((live_n + 1'b1) >> 1);

    always_comb begin
        entry     = r_rd_sent ? KEY_W'(r_window_size) : KEY_W'(r_rd_data);
        less      = entry < KEY_W'(r_bo[LOCAL_W-1:0]);
        probe_inc = r_probe + 1'b1;
        if (less) begin
            n_lo  = probe_inc;
            n_len = r_len - (r_len >> 1) - 1'b1;
        end else begin
            n_lo  = r_lo;
            n_len = r_len >> 1;
        end
        next_probe = n_lo + (n_len >> 1);
        if (i_cmd.start) begin
            if (in_op == OP_BYTE_TO_CHAR) begin
                rd_idx = probe0;
            end else begin
                rd_idx = CNT_W'(i_char_index[CHAR_W-2:0]);
            end
        end else begin
            rd_idx = next_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && in_op == OP_LOAD && load_ok) begin
            r_mem[IDX_W'(i_char_index[CHAR_W-2:0])] <=
                LOCAL_BYTE_BITS'(i_byte_offset);
        end
        r_rd_data <= r_mem[rd_idx[IDX_W-1:0]];
        r_rd_sent <= (rd_idx >= live_n);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op       <= in_op;
            r_lk_ok    <= lookup_ok;
            r_bo       <= i_byte_offset;
            r_rlen     <= i_range_length;
            r_diff     <= CLIP_W'(i_range_location)
                          - $signed({2'b00, r_window_offset});
            r_clip_pos <= !i_range_location[RANGE_W-1] && !i_range_length[RANGE_W-1]
                          && (i_range_length != '0);
            r_lo       <= '0;
            r_len      <= live_n + 1'b1;
            r_probe    <= probe0;
        end else if (i_cmd.search) begin
            r_lo    <= n_lo;
            r_len   <= n_len;
            r_probe <= next_probe;
        end
    end

    assign o_stat.op          = in_op;
    assign o_stat.search_done = r_bo[BYTE_IN_W-1] || (n_len == '0);

    // clip arithmetic on the latched difference (range start minus window start)
    logic signed [CLIP_W-1:0] clip_l, ws_ext;
    logic [LOCAL_W-1:0]       clip_room;
    logic                     before_win;
    assign ws_ext     = $signed({{(CLIP_W-LOCAL_W){1'b0}}, r_window_size});
    assign clip_l     = CLIP_W'(r_rlen) + r_diff;
    assign before_win = r_diff[CLIP_W-1] || (r_diff == '0);
    assign clip_room  = r_window_size - r_diff[LOCAL_W-1:0];

    // pending result
    t_status                   r_p_status;
    logic [BYTE_RES_W-1:0]     r_p_byte;
    logic signed [CHAR_W-1:0]  r_p_char;
    logic [LOCAL_W-1:0]        r_p_cloc, r_p_clen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_p_byte <= '0;
            r_p_char <= '0;
            r_p_cloc <= '0;
            r_p_clen <= '0;
            case (in_op)
                OP_LOAD:         r_p_status <= load_ok ? STAT_OK : STAT_BOUNDS;
                OP_CHAR_LOCAL,
                OP_CHAR_GLOBAL:  r_p_status <= lookup_ok ? STAT_OK : STAT_BOUNDS;
                OP_BYTE_TO_CHAR: r_p_status <= STAT_OK;
                OP_CLIP:         r_p_status <= STAT_NOTFOUND;
                default:         r_p_status <= STAT_BOUNDS;
            endcase
        end else if (i_cmd.lookup) begin
            if (r_lk_ok) begin
                if (r_op == OP_CHAR_GLOBAL) begin
                    r_p_byte <= BYTE_RES_W'(entry) + BYTE_RES_W'(r_window_offset);
                end else begin
                    r_p_byte <= BYTE_RES_W'(entry);
                end
            end
        end else if (i_cmd.search) begin
            if (r_bo[BYTE_IN_W-1]) begin
                r_p_char <= -16'sd1;
            end else begin
                r_p_char <= CHAR_W'(n_lo);
            end
        end else if (i_cmd.clip) begin
            if (r_clip_pos) begin
                if (before_win) begin
                    if (!clip_l[CLIP_W-1] && clip_l != '0) begin
                        r_p_status <= STAT_OK;
                        r_p_clen   <= (clip_l < ws_ext) ? clip_l[LOCAL_W-1:0]
                                                        : r_window_size;
                    end
                end else if (r_diff < ws_ext) begin
                    r_p_status <= STAT_OK;
                    r_p_cloc   <= r_diff[LOCAL_W-1:0];
                    r_p_clen   <= (r_rlen < RANGE_W'(clip_room)) ? r_rlen[LOCAL_W-1:0]
                                                                 : clip_room;
                end
            end
        end
    end

    // output register
    logic [1:0]               r_out_status;
    logic [BYTE_RES_W-1:0]    r_out_byte;
    logic signed [CHAR_W-1:0] r_out_char;
    logic [LOCAL_W-1:0]       r_out_cloc, r_out_clen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_p_status;
            r_out_byte   <= r_p_byte;
            r_out_char   <= r_p_char;
            r_out_cloc   <= r_p_cloc;
            r_out_clen   <= r_p_clen;
        end
    end

    assign o_status        = r_out_status;
    assign o_byte_result   = r_out_byte;
    assign o_char_result   = r_out_char;
    assign o_clip_location = r_out_cloc;
    assign o_clip_length   = r_out_clen;

endmodule

[sv/char_byte_offset_map.sv]
// ----------------------------------------------------------------------------
// char_byte_offset_map
// Character index to byte offset map of a text window, with range clipping.
// ----------------------------------------------------------------------------
// One word is worked at a time; the next is taken as soon as the previous
// result sits in the output register, even if that result is still stalled.
// Load and unknown ops go from idle straight to the finish state; clip and offset
// lookups pass through their own work state first (lookups do one registered read
// of the offset table there). Byte-to-char runs a lower-bound search doing one
// table read per cycle; the table's single read port sets that pace. A stalled
// result word holds the finished next one back until it is taken.
// The table has no reset: read an entry only after it was loaded.
// Window registers are written over the config port; the user must write them only
// while no word is in work, since the block itself does not enforce it.
module char_byte_offset_map
    import cbom_pkg::*;
#(
    parameter int MAX_CHARS       = 16384,
    parameter int LOCAL_BYTE_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OP_W-1:0]              i_op,
    input  logic signed [CHAR_W-1:0]     i_char_index,
    input  logic signed [BYTE_IN_W-1:0]  i_byte_offset,
    input  logic signed [RANGE_W-1:0]    i_range_location,
    input  logic signed [RANGE_W-1:0]    i_range_length,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [BYTE_RES_W-1:0]        o_byte_result,
    output logic signed [CHAR_W-1:0]     o_char_result,
    output logic [LOCAL_W-1:0]           o_clip_location,
    output logic [LOCAL_W-1:0]           o_clip_length
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    cbom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cbom_dpath #(
        .MAX_CHARS       (MAX_CHARS),
        .LOCAL_BYTE_BITS (LOCAL_BYTE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_char_index     (i_char_index),
        .i_byte_offset    (i_byte_offset),
        .i_range_location (i_range_location),
        .i_range_length   (i_range_length),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_byte_result    (o_byte_result),
        .o_char_result    (o_char_result),
        .o_clip_location  (o_clip_location),
        .o_clip_length    (o_clip_length)
    );

endmodule

[sv/cbom_checker.sv]
// ----------------------------------------------------------------------------
// cbom_checker
// Port-level checks of the offset map, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_byte_offset_map_macros.svh"

module cbom_checker
    import cbom_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [1:0]                   o_status,
    input logic [BYTE_RES_W-1:0]        o_byte_result,
    input logic signed [CHAR_W-1:0]     o_char_result,
    input logic [LOCAL_W-1:0]           o_clip_location,
    input logic [LOCAL_W-1:0]           o_clip_length
);

    // a stalled result word holds
    `CBOM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_byte_result) && $stable(o_char_result) && $stable(o_clip_location) && $stable(o_clip_length), "result word changed under stall")

    // one word in work: an accepted word makes the block busy next cycle
    `CBOM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input taken twice in a row")

    // bounds errors carry no offsets
    `CBOM_ASSERT_SAME(a_bounds_zero, o_out_valid && o_status == STAT_BOUNDS, o_byte_result == '0 && o_clip_location == '0 && o_clip_length == '0, "bounds error with nonzero offsets")

    // a missed clip reports an empty range
    `CBOM_ASSERT_SAME(a_notfound_zero, o_out_valid && o_status == STAT_NOTFOUND, o_clip_location == '0 && o_clip_length == '0 && o_byte_result == '0 && o_char_result == '0, "clip miss with nonzero fields")

endmodule

bind char_byte_offset_map cbom_checker u_cbom_checker (.*);

[test/tb_char_byte_offset_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_byte_offset_map
// Self-checking bench for the character/byte offset map. A predictor class
// mirrors the window registers and the offset table, works out the result
// of every word the block takes and checks each result word in order.
// Stimulus: directed corner words, then windows of random size and count,
// each with a sorted table load followed by mixed lookups, searches, clips,
// stray loads and unused ops. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_char_byte_offset_map;
    import cbom_pkg::*;

    localparam int CHARS = 16384;
    localparam int IDLE_PCT = 21;
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam longint WOFF_MAX = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint RANGE_MAX = 64'sd281474976710655;
    localparam longint RANGE_MIN = -64'sd281474976710656;

    typedef struct {
        logic [OP_W-1:0]             op;
        logic signed [CHAR_W-1:0]    ci;
        logic signed [BYTE_IN_W-1:0] bo;
        logic signed [RANGE_W-1:0]   rloc;
        logic signed [RANGE_W-1:0]   rlen;
    } t_word;

    typedef struct {
        logic [1:0]               status;
        logic [BYTE_RES_W-1:0]    byte_res;
        logic signed [CHAR_W-1:0] char_res;
        logic [LOCAL_W-1:0]       clip_loc;
        logic [LOCAL_W-1:0]       clip_len;
    } t_map_result;

    class offset_map_board;
        logic [WOFF_W-1:0]  win_offset;
        logic [LOCAL_W-1:0] win_size;
        logic [COUNT_W-1:0] char_total;
        logic [LOCAL_W-1:0] offsets [CHARS];
        t_map_result        pending_results [$];
        int                 errors;

        function new();
            win_offset = '0;
            win_size = '0;
            char_total = '0;
            errors = 0;
        endfunction

        function int chars_live();
            if (char_total > CHARS) return CHARS;
            return int'(char_total);
        endfunction

        // index chars_live() is the window-size sentinel
        function longint offset_of(longint i);
            if (i >= chars_live()) return longint'(win_size);
            return longint'(offsets[i]);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW_OFFSET: win_offset = data[WOFF_W-1:0];
                CFG_WINDOW_SIZE:   win_size = data[LOCAL_W-1:0];
                CFG_CHAR_COUNT:    char_total = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_word(t_word w);
            t_map_result r;
            longint n, ci, bo, rloc, rlen, wo, ws, lo, len, half, l, loc, room;
            r.status = STAT_OK;
            r.byte_res = '0;
            r.char_res = '0;
            r.clip_loc = '0;
            r.clip_len = '0;
            n = chars_live();
            ci = w.ci;
            bo = w.bo;
            rloc = w.rloc;
            rlen = w.rlen;
            wo = longint'(win_offset);
            ws = longint'(win_size);
            case (w.op)
                OP_LOAD: begin
                    if (ci < 0 || ci >= CHARS) r.status = STAT_BOUNDS;
                    else offsets[ci] = w.bo[LOCAL_W-1:0];
                end
                OP_CHAR_LOCAL, OP_CHAR_GLOBAL: begin
                    if (ci < 0 || ci > n) begin
                        r.status = STAT_BOUNDS;
                    end else begin
                        r.byte_res = BYTE_RES_W'(offset_of(ci));
                        if (w.op == OP_CHAR_GLOBAL)
                            r.byte_res = r.byte_res + BYTE_RES_W'(win_offset);
                    end
                end
                OP_BYTE_TO_CHAR: begin
                    if (bo < 0) begin
                        r.char_res = -16'sd1;
                    end else begin
                        // lower bound over entries 0..n, sentinel included
                        lo = 0;
                        len = n + 1;
                        while (len > 0) begin
                            half = len >> 1;
                            if (offset_of(lo + half) < bo) begin
                                lo = lo + half + 1;
                                len = len - half - 1;
                            end else begin
                                len = half;
                            end
                        end
                        r.char_res = CHAR_W'(lo);
                    end
                end
                OP_CLIP: begin
                    r.status = STAT_NOTFOUND;
                    if (rloc >= 0 && rlen > 0) begin
                        if (rloc <= wo) begin
                            l = rlen - wo + rloc;
                            if (l > 0) begin
                                r.status = STAT_OK;
                                r.clip_len = LOCAL_W'((l < ws) ? l : ws);
                            end
                        end else if (rloc < wo + ws) begin
                            loc = rloc - wo;
                            room = ws - loc;
                            r.status = STAT_OK;
                            r.clip_loc = LOCAL_W'(loc);
                            r.clip_len = LOCAL_W'((rlen < room) ? rlen : room);
                        end
                    end
                end
                default: r.status = STAT_BOUNDS;
            endcase
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
        endtask

        task check_result(t_map_result got);
            t_map_result want;
            if (pending_results.size() == 0) begin
                report("result word with none pending", 64'd0, 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.byte_res !== want.byte_res)
                report("byte_result", got.byte_res, want.byte_res);
            if (got.char_res !== want.char_res)
                report("char_result", got.char_res, want.char_res);
            if (got.clip_loc !== want.clip_loc)
                report("clip_location", got.clip_loc, want.clip_loc);
            if (got.clip_len !== want.clip_len)
                report("clip_length", got.clip_len, want.clip_len);
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [OP_W-1:0]             i_op = '0;
    logic signed [CHAR_W-1:0]    i_char_index = '0;
    logic signed [BYTE_IN_W-1:0] i_byte_offset = '0;
    logic signed [RANGE_W-1:0]   i_range_location = '0;
    logic signed [RANGE_W-1:0]   i_range_length = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [1:0]                  o_status;
    logic [BYTE_RES_W-1:0]       o_byte_result;
    logic signed [CHAR_W-1:0]    o_char_result;
    logic [LOCAL_W-1:0]          o_clip_location;
    logic [LOCAL_W-1:0]          o_clip_length;

    offset_map_board sb;
    int in_idle_pct = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;

    char_byte_offset_map dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_char_index     (i_char_index),
        .i_byte_offset    (i_byte_offset),
        .i_range_location (i_range_location),
        .i_range_length   (i_range_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_byte_result    (o_byte_result),
        .o_char_result    (o_char_result),
        .o_clip_location  (o_clip_location),
        .o_clip_length    (o_clip_length)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_word make_word(logic [OP_W-1:0] op, longint ci, longint bo,
                                        longint rloc, longint rlen);
        t_word w;
        w.op = op;
        w.ci = ci[CHAR_W-1:0];
        w.bo = bo[BYTE_IN_W-1:0];
        w.rloc = rloc[RANGE_W-1:0];
        w.rlen = rlen[RANGE_W-1:0];
        return w;
    endfunction

    function automatic t_word random_word();
        t_word w;
        int pick, idx;
        longint n, ws, wo, lo, hi, v, len;
        logic [63:0] r1, r2;
        n = sb.chars_live();
        ws = longint'(sb.win_size);
        wo = longint'(sb.win_offset);
        r1 = rand64();
        r2 = rand64();
        // unused fields carry noise
        w.op = OP_LOAD;
        w.ci = r2[63:48];
        w.bo = r1[63:43];
        w.rloc = r1[48:0];
        w.rlen = r2[48:0];
        pick = $urandom_range(99);
        if (pick < 15) begin
            w.op = OP_LOAD;
            case ($urandom_range(5))
                0, 1, 2: begin
                    // rewrite a live entry, keeping the table sorted
                    if (n > 0) begin
                        idx = $urandom_range(0, int'(n) - 1);
                        lo = (idx > 0) ? longint'(sb.offsets[idx-1]) : 0;
                        hi = (idx + 1 < n) ? longint'(sb.offsets[idx+1]) : ws;
                        w.ci = CHAR_W'(idx);
                        w.bo = BYTE_IN_W'($urandom_range(int'(lo), int'(hi)));
                    end
                end
                3: begin
                    if (n < CHARS) w.ci = CHAR_W'($urandom_range(int'(n), CHARS - 1));
                    else w.ci = CHAR_W'($urandom_range(CHARS, 32767));
                end
                4: w.ci = CHAR_W'(n);
                default: begin
                    case ($urandom_range(3))
                        0: w.ci = -16'sd1;
                        1: w.ci = CHAR_W'(CHARS);
                        2: w.ci = CHAR_W'(CHARS + 1);
                        default: w.ci = -CHAR_W'($urandom_range(1, 32768));
                    endcase
                end
            endcase
        end else if (pick < 41) begin
            w.op = (pick < 28) ? OP_CHAR_LOCAL : OP_CHAR_GLOBAL;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: w.ci = CHAR_W'($urandom_range(0, int'(n)));
                6: w.ci = CHAR_W'(n);
                7: w.ci = -16'sd1;
                8: w.ci = CHAR_W'(n + 1);
                default: ;
            endcase
        end else if (pick < 68) begin
            w.op = OP_BYTE_TO_CHAR;
            v = sb.offset_of($urandom_range(0, int'(n)));
            case ($urandom_range(9))
                0, 1, 2: ;
                3: v = v + 1;
                4: v = v - 1;
                5: v = $urandom_range(0, int'(ws) + 1);
                6: v = ws + $urandom_range(1, 100);
                7: v = -longint'($urandom_range(1, 1048576));
                8: v = longint'(w.bo);
                default: v = 0;
            endcase
            w.bo = v[BYTE_IN_W-1:0];
        end else if (pick < 95) begin
            w.op = OP_CLIP;
            v = longint'(w.rloc);
            case ($urandom_range(9))
                0, 1, 2, 3: v = wo - ws - 4 + longint'($urandom_range(0, 2 * int'(ws) + 8));
                4: v = wo;
                5: v = wo + ws;
                6: v = wo + ws - 1;
                7: v = wo - 1;
                8: v = -longint'($urandom_range(1, 1000));
                default: ;
            endcase
            w.rloc = v[RANGE_W-1:0];
            len = longint'(w.rlen);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: len = $urandom_range(1, int'(ws) + 8);
                5: len = 0;
                6: len = -longint'($urandom_range(1, 1000));
                7: len = wo + ws - v;
                8: len = $urandom_range(1, 1 << 30);
                default: ;
            endcase
            w.rlen = len[RANGE_W-1:0];
        end else begin
            w.op = OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
        end
        return w;
    endfunction

    task automatic send_word(input t_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= w.op;
        i_char_index <= w.ci;
        i_byte_offset <= w.bo;
        i_range_location <= w.rloc;
        i_range_length <= w.rlen;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
    endtask

    task automatic wait_results_done();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // drain, program the window, optionally load a sorted table, then random words
    task automatic run_window(input logic [WOFF_W-1:0] woff, input logic [LOCAL_W-1:0] wsz,
                              input logic [COUNT_W-1:0] cnt, input bit refill,
                              input int words);
        t_cfg_reg regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int first, idx, n, stepmax;
        longint prev, v;
        regs[0] = CFG_WINDOW_OFFSET;
        regs[1] = CFG_WINDOW_SIZE;
        regs[2] = CFG_CHAR_COUNT;
        vals[0] = woff;
        vals[1] = CFG_DATA_W'(wsz);
        vals[2] = CFG_DATA_W'(cnt);
        // the last word was taken; drop valid so it is not taken again
        i_in_valid <= 1'b0;
        wait_results_done();
        first = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            idx = (first + k) % 3;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[idx];
            i_cfg_data <= vals[idx];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(regs[idx], vals[idx]);
        end
        i_cfg_valid <= 1'b0;
        if (refill) begin
            n = sb.chars_live();
            stepmax = int'((2 * longint'(wsz)) / ((n > 0) ? n : 1)) + 1;
            prev = 0;
            for (int i = 0; i < n; i++) begin
                v = prev + $urandom_range(0, stepmax);
                if ($urandom_range(3) == 0) v = prev;
                if (v > longint'(wsz)) v = longint'(wsz);
                send_word(make_word(OP_LOAD, i, v, longint'(rand64()), 0));
                prev = v;
            end
        end
        repeat (words) send_word(random_word());
    endtask

    always @(posedge i_clk) begin : result_side
        t_map_result got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.status = o_status;
                got.byte_res = o_byte_result;
                got.char_res = o_char_result;
                got.clip_loc = o_clip_location;
                got.clip_len = o_clip_length;
                sb.check_result(got);
            end
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    initial begin : stimulus
        logic [63:0] r;
        logic [WOFF_W-1:0] woff;
        logic [LOCAL_W-1:0] wsz;
        logic [COUNT_W-1:0] cnt;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty window straight out of reset: only the sentinel exists
        send_word(make_word(OP_CHAR_LOCAL, 0, 0, 0, 0));
        send_word(make_word(OP_CHAR_GLOBAL, 0, 0, 0, 0));
        send_word(make_word(OP_CHAR_LOCAL, -1, 0, 0, 0));
        send_word(make_word(OP_CHAR_GLOBAL, 1, 0, 0, 0));
        send_word(make_word(OP_BYTE_TO_CHAR, 0, -1048576, 0, 0));
        send_word(make_word(OP_BYTE_TO_CHAR, 0, 0, 0, 0));
        send_word(make_word(OP_BYTE_TO_CHAR, 0, 1048575, 0, 0));
        send_word(make_word(OP_CLIP, 0, 0, 0, 1));
        send_word(make_word(OP_CLIP, 0, 0, RANGE_MIN, 5));
        send_word(make_word(OP_CLIP, 0, 0, 0, 0));
        send_word(make_word(OP_CLIP, 0, 0, 7, RANGE_MIN));
        send_word(make_word(OP_LOAD, -1, 3, 0, 0));
        send_word(make_word(OP_LOAD, CHARS, 3, 0, 0));
        send_word(make_word(OP_LOAD, CHARS + 1, -1, 0, 0));
        send_word(make_word(OP_FIRST_UNUSED, 0, 0, 0, 0));
        send_word(make_word(OP_FIRST_UNUSED + 3'd1, -1, -1, -1, -1));
        send_word(make_word(OP_FIRST_UNUSED + 3'd2, 0, 0, RANGE_MAX, RANGE_MAX));

        // widest window, three characters; load at the count is shadowed
        run_window(WOFF_MAX[WOFF_W-1:0], 20'hFFFFF, 15'd3, 1'b0, 0);
        send_word(make_word(OP_LOAD, 0, 0, 0, 0));
        send_word(make_word(OP_LOAD, 1, 7, 0, 0));
        send_word(make_word(OP_LOAD, 2, 1048575, 0, 0));
        send_word(make_word(OP_LOAD, 3, -1048576, 0, 0));
        send_word(make_word(OP_CHAR_LOCAL, 3, 0, 0, 0));
        send_word(make_word(OP_CHAR_GLOBAL, 2, 0, 0, 0));
        send_word(make_word(OP_BYTE_TO_CHAR, 0, 1048575, 0, 0));
        send_word(make_word(OP_BYTE_TO_CHAR, 0, 8, 0, 0));
        send_word(make_word(OP_CLIP, 0, 0, WOFF_MAX, RANGE_MAX));
        send_word(make_word(OP_CLIP, 0, 0, WOFF_MAX - 5, 5));

        run_window(48'd0, 20'd0, 15'd5, 1'b1, 40);

        for (int p = 0; p < 8; p++) begin
            r = rand64();
            case ($urandom_range(3))
                0: woff = '0;
                1: woff = '1;
                2: woff = r[WOFF_W-1:0];
                default: woff = WOFF_W'($urandom_range(0, 1000));
            endcase
            case ($urandom_range(3))
                0: wsz = LOCAL_W'($urandom_range(0, 64));
                1: wsz = LOCAL_W'($urandom_range(65, 5000));
                2: wsz = r[63:44];
                default: wsz = '1;
            endcase
            case ($urandom_range(3))
                0: cnt = '0;
                1: cnt = COUNT_W'($urandom_range(1, 3));
                2: cnt = COUNT_W'($urandom_range(4, 40));
                default: cnt = COUNT_W'($urandom_range(41, 150));
            endcase
            run_window(woff, wsz, cnt, 1'b1, 30);

            if (p == 3) begin
                // no idling on either side
                in_idle_pct = 0;
                out_idle_pct = 0;
                r = rand64();
                run_window(r[WOFF_W-1:0], 20'hFFFFF, 15'd80, 1'b1, 30);
                in_idle_pct = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
                // counts above the table size clamp to it; only the sentinel
                // and the bounds are touched, no table entry is read
                run_window(48'd12, 20'hFFFFF, '1, 1'b0, 0);
                send_word(make_word(OP_CHAR_LOCAL, CHARS, 0, 0, 0));
                send_word(make_word(OP_CHAR_GLOBAL, CHARS, 0, 0, 0));
                send_word(make_word(OP_CHAR_LOCAL, CHARS + 1, 0, 0, 0));
                send_word(make_word(OP_LOAD, CHARS, 5, 0, 0));
                send_word(make_word(OP_BYTE_TO_CHAR, 0, -1, 0, 0));
                send_word(make_word(OP_CLIP, 0, 0, 10, 100));
                run_window(48'd12, 20'hFFFFF, 15'(CHARS + 1), 1'b0, 0);
                send_word(make_word(OP_CHAR_GLOBAL, CHARS, 0, 0, 0));
                send_word(make_word(OP_CHAR_LOCAL, CHARS + 1, 0, 0, 0));
            end
        end

        i_in_valid <= 1'b0;
        wait_results_done();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[char_byte_offset_map.f]
+incdir+sv
sv/cbom_pkg.sv
sv/cbom_ctrl.sv
sv/cbom_dpath.sv
sv/char_byte_offset_map.sv
sv/cbom_checker.sv
test/tb_char_byte_offset_map.sv
